// ----- hdl/cbms_pkg.sv -----
// Package for the CPU busy median sampler: field widths, defaults and the
// controller state type. No dependencies; every other file imports it.
`timescale 1ns / 1ps
`default_nettype none

package cbms_pkg;

  // Fixed field widths of the request and result channels.
  localparam int TICK_W   = 31;
  localparam int MEDIAN_W = 23;
  localparam int COUNT_W  = 7;

  // Defaults for the top-level parameters.
  localparam int SAMPLES_MAX_DEF   = 64;
  localparam int FRACTION_BITS_DEF = 16;

  // Items per round after reset.
  localparam logic [COUNT_W-1:0] SAMPLE_COUNT_RESET = 7'd10;

  // Full scale of the busy value before shifting in the fraction.
  localparam int PERCENT_FULL = 100;

  // Controller states.
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SUM,
    ST_DIV,
    ST_DECIDE,
    ST_CMP,
    ST_PUT,
    ST_STEP,
    ST_MED,
    ST_OUT
  } state_t;

endpackage

`default_nettype wire

// ----- hdl/cbms_if.sv -----
// Channel interfaces of the CPU busy median sampler: sample requests,
// median results and the configuration write channel. Depends on cbms_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface cbms_sample_if;
  import cbms_pkg::*;
  logic              valid;
  logic              ready;
  logic              read_ok;
  logic [TICK_W-1:0] user_ticks;
  logic [TICK_W-1:0] nice_ticks;
  logic [TICK_W-1:0] kernel_ticks;
  logic [TICK_W-1:0] idle_ticks;
  logic [TICK_W-1:0] iowait_ticks;
  logic [TICK_W-1:0] irq_ticks;
  logic [TICK_W-1:0] softirq_ticks;

  modport source (output valid, read_ok, user_ticks, nice_ticks, kernel_ticks, idle_ticks,
                  iowait_ticks, irq_ticks, softirq_ticks, input ready);
  modport sink (input valid, read_ok, user_ticks, nice_ticks, kernel_ticks, idle_ticks,
                iowait_ticks, irq_ticks, softirq_ticks, output ready);
endinterface

interface cbms_result_if;
  import cbms_pkg::*;
  logic                valid;
  logic                ready;
  logic [MEDIAN_W-1:0] median_busy;
  logic [COUNT_W-1:0]  kept_count;
  logic                empty_round;

  modport source (output valid, median_busy, kept_count, empty_round, input ready);
  modport sink (input valid, median_busy, kept_count, empty_round, output ready);
endinterface

interface cbms_cfg_if;
  import cbms_pkg::*;
  logic               valid;
  logic               ready;
  logic [COUNT_W-1:0] data;

  modport source (output valid, data, input ready);
  modport sink (input valid, data, output ready);
endinterface

`default_nettype wire

// ----- hdl/cpu_busy_median_sampler_top.sv -----
// CPU busy median sampler: busy percent per sample by a radix-2 divider,
// sorted insertion into a synchronous store, median at the end of each round.
// Depends on cbms_pkg and the interfaces in cbms_if.sv.
//
//   channel    dir  fields
//   samples    in   read_ok, seven 31-bit tick counters
//   results    out  median_busy, kept_count, empty_round
//   cfg        in   data = sample_count (7 bits)
//
// One item passes ST_IDLE (capture, pairwise sums), ST_SUM, the ST_DIV loop
// (QUO_W = FRACTION_BITS + 7 quotient bits), ST_DECIDE, insertion through
// ST_CMP or ST_PUT over the one-read, one-write store port, and ST_STEP.
// The last item of a round adds ST_MED (median read) and ST_OUT (result load).
// Reset (rst, synchronous) clears the round counters and sets sample_count
// to 10; the store needs no clearing. A stalled result holds in the output
// register while the next item is already being taken and worked on.
`timescale 1ns / 1ps
`default_nettype none

module cpu_busy_median_sampler_top #(
  parameter int SAMPLES_MAX   = cbms_pkg::SAMPLES_MAX_DEF,
  parameter int FRACTION_BITS = cbms_pkg::FRACTION_BITS_DEF
) (
  input wire logic      clk,
  input wire logic      rst,
  cbms_sample_if.sink   samples,
  cbms_result_if.source results,
  cbms_cfg_if.sink      cfg
);
  import cbms_pkg::*;

  // Derived widths.
  localparam int QUO_W  = FRACTION_BITS + 7;          // holds 100 << FRACTION_BITS
  localparam int SUM_W  = TICK_W + 3;                 // sum of seven counters
  localparam int PROD_W = TICK_W + QUO_W;
  localparam int KEPT_W = $clog2(SAMPLES_MAX + 1);
  localparam int ADDR_W = (SAMPLES_MAX > 1) ? $clog2(SAMPLES_MAX) : 1;
  localparam int CNT_W  = $clog2(QUO_W + 1);
  localparam logic [QUO_W-1:0]  FULL     = QUO_W'(PERCENT_FULL) << FRACTION_BITS;
  localparam logic [KEPT_W-1:0] KEPT_MAX = KEPT_W'(SAMPLES_MAX);
  localparam logic [CNT_W-1:0]  DIV_STEPS = CNT_W'(QUO_W);

  state_t state, state_next;

  // Configuration and round counters.
  logic [COUNT_W-1:0] sample_count;
  logic [COUNT_W-1:0] items;
  logic [KEPT_W-1:0]  kept;

  // Sample datapath registers.
  logic              ok_q;
  logic [TICK_W:0]   pair0, pair1, pair2;
  logic [TICK_W-1:0] pair3;
  logic [TICK_W-1:0] idle_q;
  logic [SUM_W-1:0]  sum;
  logic [SUM_W-1:0]  rem;
  logic [QUO_W-1:0]  quo;
  logic [CNT_W-1:0]  dcnt;
  logic [QUO_W-1:0]  busy;
  logic [KEPT_W-1:0] pos;

  // Sorted store.
  logic [QUO_W-1:0] store [SAMPLES_MAX];
  logic [QUO_W-1:0] rdata;
  logic             mem_we, mem_re;
  logic [KEPT_W-1:0] mem_waddr, mem_raddr;
  logic [QUO_W-1:0] mem_wdata;

  // Output register.
  logic                out_valid;
  logic [MEDIAN_W-1:0] out_median;
  logic [COUNT_W-1:0]  out_count;
  logic                out_empty;

  // Combinational datapath terms.
  logic [PROD_W-1:0]  product;
  logic [SUM_W:0]     trial;
  logic               trial_ge;
  logic [SUM_W-1:0]   rem_next;
  logic [QUO_W:0]     q_ceil;
  logic [QUO_W-1:0]   busy_calc;
  logic               keep;
  logic [COUNT_W-1:0] items_inc;
  logic               round_end;
  logic               out_free;
  logic [QUO_W+MEDIAN_W-1:0] median_ext;
  logic [KEPT_W+COUNT_W-1:0] count_ext;

  // Idle share times full scale; divided by the sum in the loop below.
  assign product = PROD_W'(idle_q) * PROD_W'(FULL);

  // One restoring division step per cycle.
  assign trial    = {rem, quo[QUO_W-1]};
  assign trial_ge = trial >= {1'b0, sum};
  assign rem_next = trial_ge ? SUM_W'(trial - {1'b0, sum}) : trial[SUM_W-1:0];

  // Busy = full - ceil(idle * full / sum); idle never exceeds the sum.
  assign q_ceil    = {1'b0, quo} + {{QUO_W{1'b0}}, (rem != '0)};
  assign busy_calc = (q_ceil >= {1'b0, FULL}) ? '0 : FULL - q_ceil[QUO_W-1:0];
  assign keep      = ok_q && (sum != '0) && (busy_calc != '0) && (kept < KEPT_MAX);

  assign items_inc = items + COUNT_W'(1);
  assign round_end = items_inc >= sample_count;
  assign out_free  = !out_valid || results.ready;

  assign median_ext = {{MEDIAN_W{1'b0}}, rdata};
  assign count_ext  = {{COUNT_W{1'b0}}, kept};

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:   if (samples.valid) state_next = ST_SUM;
      ST_SUM:    state_next = ST_DIV;
      ST_DIV:    if (dcnt == CNT_W'(1)) state_next = ST_DECIDE;
      ST_DECIDE: begin
        if (!keep) state_next = ST_STEP;
        else if (kept == '0) state_next = ST_PUT;
        else state_next = ST_CMP;
      end
      ST_CMP: begin
        if (rdata > busy) begin
          if (pos == KEPT_W'(1)) state_next = ST_PUT;
        end else begin
          state_next = ST_STEP;
        end
      end
      ST_PUT:    state_next = ST_STEP;
      ST_STEP:   state_next = round_end ? ST_MED : ST_IDLE;
      ST_MED:    state_next = ST_OUT;
      ST_OUT:    if (out_free) state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  // Handshake and store control.
  always_comb begin
    samples.ready = (state == ST_IDLE);
    cfg.ready     = 1'b1;
    mem_we        = 1'b0;
    mem_waddr     = pos;
    mem_wdata     = busy;
    mem_re        = 1'b0;
    mem_raddr     = kept - KEPT_W'(1);
    case (state)
      ST_DECIDE: begin
        mem_re    = keep && (kept != '0);
        mem_raddr = kept - KEPT_W'(1);
      end
      ST_CMP: begin
        mem_we = 1'b1;
        if (rdata > busy) begin
          mem_wdata = rdata;
          mem_re    = (pos != KEPT_W'(1));
          mem_raddr = pos - KEPT_W'(2);
        end
      end
      ST_PUT:  mem_we = 1'b1;
      ST_STEP: begin
        mem_re    = round_end;
        mem_raddr = kept >> 1;
      end
      default: begin
        mem_we = 1'b0;
        mem_re = 1'b0;
      end
    endcase
  end

  // Store: one write port, one read port with registered data.
  always_ff @(posedge clk) begin
    if (mem_we) store[mem_waddr[ADDR_W-1:0]] <= mem_wdata;
    if (mem_re) rdata <= store[mem_raddr[ADDR_W-1:0]];
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      sample_count <= SAMPLE_COUNT_RESET;
      items        <= '0;
      kept         <= '0;
      out_valid    <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg.valid && cfg.ready) sample_count <= cfg.data;
      if (state == ST_STEP) items <= round_end ? '0 : items_inc;
      if ((state == ST_PUT) || (state == ST_CMP && !(rdata > busy))) begin
        kept <= kept + KEPT_W'(1);
      end
      if (state == ST_OUT && out_free) begin
        kept      <= '0;
        out_valid <= 1'b1;
      end else if (results.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        ok_q   <= samples.read_ok;
        pair0  <= {1'b0, samples.user_ticks} + {1'b0, samples.nice_ticks};
        pair1  <= {1'b0, samples.kernel_ticks} + {1'b0, samples.idle_ticks};
        pair2  <= {1'b0, samples.iowait_ticks} + {1'b0, samples.irq_ticks};
        pair3  <= samples.softirq_ticks;
        idle_q <= samples.idle_ticks;
      end
      ST_SUM: begin
        sum  <= (SUM_W'(pair0) + SUM_W'(pair1)) + (SUM_W'(pair2) + SUM_W'(pair3));
        rem  <= SUM_W'(product[PROD_W-1:QUO_W]);
        quo  <= product[QUO_W-1:0];
        dcnt <= DIV_STEPS;
      end
      ST_DIV: begin
        rem  <= rem_next;
        quo  <= {quo[QUO_W-2:0], trial_ge};
        dcnt <= dcnt - CNT_W'(1);
      end
      ST_DECIDE: begin
        busy <= busy_calc;
        pos  <= kept;
      end
      ST_CMP: if (rdata > busy) pos <= pos - KEPT_W'(1);
      default: begin
        busy <= busy;
      end
    endcase
    if (state == ST_OUT && out_free) begin
      out_median <= (kept == '0) ? '0 : median_ext[MEDIAN_W-1:0];
      out_count  <= count_ext[COUNT_W-1:0];
      out_empty  <= (kept == '0);
    end
  end

  assign results.valid       = out_valid;
  assign results.median_busy = out_median;
  assign results.kept_count  = out_count;
  assign results.empty_round = out_empty;

  // The store never holds more samples than it has entries.
  a_kept_bound: assert property (@(posedge clk) disable iff (rst) kept <= KEPT_MAX)
    else $error("kept count above store depth");

  // The kept count only steps up by one or clears at the end of a round.
  a_kept_step: assert property (@(posedge clk) disable iff (rst)
    (kept != $past(kept)) |-> (kept == $past(kept) + KEPT_W'(1)) || (kept == '0))
    else $error("kept count jumped");

  // After the division loop the remainder is below the divisor.
  a_div_rem: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DECIDE) && (sum != '0) |-> rem < sum)
    else $error("divider remainder not reduced");

  // An empty round reports zero for the median and the count.
  a_empty: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_empty |-> (out_median == '0) && (out_count == '0))
    else $error("empty round with nonzero result");

endmodule

`default_nettype wire
